// ===== design/tccs_pkg.sv =====
// Package for the text console engine: geometry constants, mode and
// state codes, item, result and screen memory request types.
// No dependencies; every module of the console imports it.
package tccs_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field and storage widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Character and attribute constants
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    // Item mode codes
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_DEL_WR,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK
    } state_t;

    // One input item
    typedef struct packed {
        logic [1:0]        mode;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } item_t;

    // One result item
    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_linear;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } result_t;

    // Screen memory access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage

// ===== design/text_console_cursor_scroll.sv =====
// Top level of the text console engine: configuration register, output
// register, and the sequencer, address unit and screen memory below it.
// Depends on tccs_pkg, tccs_ctrl, tccs_addr_unit and tccs_screen_ram.
//
// Usage:
//   item channel (item_valid / item_stall / item) takes put, delete and read
//   items; result channel (result_valid / result_stall / result) returns one
//   result per item, in order. cfg_write / cfg_data set the attribute byte.
// Sequence:
//   After reset the block sweeps the screen to zero, one cell a cycle, with
//   item_stall high. Then each item is accepted, executed and handed over;
//   a delete adds a write step and an in-range read a read-wait step. A put
//   that scrolls copies rows 1..24 up, reading then writing each cell, through
//   the single memory port pair and blanks the last row.
// Stalls:
//   The finished result sits in an output register; the block takes the next
//   item while it waits, but holds that item's result until the register
//   empties. A stalled result holds steady.
module text_console_cursor_scroll (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  tccs_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tccs_pkg::result_t           result,
    input  logic                        cfg_write,
    input  logic [tccs_pkg::ATTR_W-1:0] cfg_data
);
    import tccs_pkg::*;

    logic [ATTR_W-1:0] attr_reg;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    ram_req_t          ram_req;
    logic [CELL_W-1:0] rd_data;
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [ADDR_W-1:0] addr_lin;
    logic              out_free;
    logic              result_load;
    result_t           ctrl_result;

    tccs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_stall  (item_stall),
        .attr        (attr_reg),
        .ram_req     (ram_req),
        .rd_data     (rd_data),
        .addr_row    (addr_row),
        .addr_col    (addr_col),
        .addr_lin    (addr_lin),
        .out_free    (out_free),
        .result_load (result_load),
        .result      (ctrl_result)
    );

    tccs_addr_unit u_addr (
        .row (addr_row),
        .col (addr_col),
        .lin (addr_lin)
    );

    tccs_screen_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_write)
        begin
            attr_reg <= cfg_data;
        end
    end

    // Output register: free when empty or being taken this cycle
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_load)
        begin
            result_valid_next = 1'b1;
            result_next       = ctrl_result;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/tccs_screen_ram.sv =====
// Screen cell store: one write port and one read port with registered data.
// Depends on tccs_pkg for geometry and the request type.
module tccs_screen_ram (
    input  logic                     clk,
    input  tccs_pkg::ram_req_t       req,
    output logic [tccs_pkg::CELL_W-1:0] rd_data
);
    import tccs_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tccs_addr_unit.sv =====
// Shared address unit: turns a (row, column) pair into a linear cell index.
// Depends on tccs_pkg; used for cell writes, reads and the cursor position.
module tccs_addr_unit (
    input  logic [tccs_pkg::ROW_W-1:0]  row,
    input  logic [tccs_pkg::COL_W-1:0]  col,
    output logic [tccs_pkg::ADDR_W-1:0] lin
);
    import tccs_pkg::*;

    // row * COLUMNS + col, constant multiply
    assign lin = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);

endmodule

// ===== design/tccs_ctrl.sv =====
// Console sequencer: cursor state, item decode, scroll and clear sweeps.
// Depends on tccs_pkg; drives the screen memory and the shared address unit.
module tccs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  tccs_pkg::item_t             item,
    output logic                        item_stall,
    input  logic [tccs_pkg::ATTR_W-1:0] attr,
    output tccs_pkg::ram_req_t          ram_req,
    input  logic [tccs_pkg::CELL_W-1:0] rd_data,
    output logic [tccs_pkg::ROW_W-1:0]  addr_row,
    output logic [tccs_pkg::COL_W-1:0]  addr_col,
    input  logic [tccs_pkg::ADDR_W-1:0] addr_lin,
    input  logic                        out_free,
    output logic                        result_load,
    output tccs_pkg::result_t           result
);
    import tccs_pkg::*;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;
    logic               scrolled_reg, scrolled_next;
    logic               done_reg, done_next;

    logic               accept;
    logic               is_newline;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic               wrap;
    logic               scroll;
    logic               read_ok;
    logic               sweep_last;

    assign accept     = item_valid && (state_reg == ST_IDLE) && !done_reg;
    assign is_newline = (item_reg.char_code == NEWLINE_CHAR);
    assign col_inc    = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign row_inc    = {1'b0, cur_row_reg} + (ROW_W+1)'(1);
    assign wrap       = is_newline || (int'(col_inc) >= COLUMNS);
    assign scroll     = wrap && (int'(row_inc) >= ROWS);
    assign read_ok    = (int'(item_reg.read_row) < ROWS) && (int'(item_reg.read_col) < COLUMNS);
    assign sweep_last = (int'(sweep_reg) == CELLS - 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.mode)
                    MODE_PUT:    state_next = scroll ? ST_SCROLL_RD : ST_IDLE;
                    MODE_DELETE: state_next = ST_DEL_WR;
                    MODE_READ:   state_next = read_ok ? ST_READ_WAIT : ST_IDLE;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_READ_WAIT: state_next = ST_IDLE;
            ST_DEL_WR:    state_next = ST_IDLE;
            ST_SCROLL_RD: state_next = ST_SCROLL_WR;
            ST_SCROLL_WR:
            begin
                if (int'(sweep_reg) == CELLS - COLUMNS - 1)
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    state_next = ST_SCROLL_RD;
                end
            end
            ST_BLANK:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory requests, address unit operands, handshake
    always_comb
    begin
        ram_req    = '0;
        addr_row   = cur_row_reg;
        addr_col   = cur_col_reg;
        item_stall = (state_reg != ST_IDLE) || done_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_reg;
                ram_req.wr_data = '0;
            end
            ST_EXEC:
            begin
                if (item_reg.mode == MODE_READ)
                begin
                    addr_row       = item_reg.read_row;
                    addr_col       = item_reg.read_col;
                    ram_req.rd_en  = read_ok;
                    ram_req.rd_addr = addr_lin;
                end
                else if (item_reg.mode == MODE_PUT && !is_newline)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = addr_lin;
                    ram_req.wr_data = {attr, item_reg.char_code};
                end
            end
            ST_DEL_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = addr_lin;
                ram_req.wr_data = {attr, BLANK_CHAR};
            end
            ST_SCROLL_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = sweep_reg + ADDR_W'(COLUMNS);
            end
            ST_SCROLL_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_reg;
                ram_req.wr_data = rd_data;
            end
            ST_BLANK:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_reg;
                ram_req.wr_data = {attr, BLANK_CHAR};
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        item_next     = item_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        sweep_next    = sweep_reg;
        cell_next     = cell_reg;
        scrolled_next = scrolled_reg;
        done_next     = done_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next     = item;
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (item_reg.mode == MODE_PUT)
                begin
                    cur_col_next  = wrap ? '0 : col_inc[COL_W-1:0];
                    if (scroll)
                    begin
                        cur_row_next = ROW_W'(ROWS - 1);
                    end
                    else if (wrap)
                    begin
                        cur_row_next = row_inc[ROW_W-1:0];
                    end
                    scrolled_next = scroll;
                    done_next     = !scroll;
                end
                else if (item_reg.mode == MODE_DELETE)
                begin
                    if (cur_col_reg != '0)
                    begin
                        cur_col_next = cur_col_reg - COL_W'(1);
                    end
                    else if (cur_row_reg != '0)
                    begin
                        cur_row_next = cur_row_reg - ROW_W'(1);
                        cur_col_next = COL_W'(COLUMNS - 1);
                    end
                end
                else
                begin
                    done_next = !(item_reg.mode == MODE_READ && read_ok);
                end
            end
            ST_READ_WAIT:
            begin
                cell_next = rd_data;
                done_next = 1'b1;
            end
            ST_DEL_WR:
            begin
                done_next = 1'b1;
            end
            ST_SCROLL_WR:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
            end
            ST_BLANK:
            begin
                sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
                done_next  = sweep_last;
            end
            default:
            begin
                sweep_next = sweep_reg;
            end
        endcase
        // finished result moves to the output register when it is free
        if (done_reg && out_free)
        begin
            done_next = 1'b0;
        end
    end

    // Result assembly; the address unit sees the cursor while a result waits
    assign result_load          = done_reg && out_free;
    assign result.cursor_col    = cur_col_reg;
    assign result.cursor_row    = cur_row_reg;
    assign result.cursor_linear = addr_lin;
    assign result.cell_data     = cell_reg;
    assign result.scrolled      = scrolled_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            sweep_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            sweep_reg    <= sweep_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cell_reg     <= cell_next;
        scrolled_reg <= scrolled_next;
    end

    // Cursor never leaves the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_col_reg) < COLUMNS) && (int'(cur_row_reg) < ROWS))
        else $error("cursor out of range");

    // Memory never sees a read and a write in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.wr_en && ram_req.rd_en))
        else $error("read and write in same cycle");

    // A pending result blocks new items until it moves out
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE) && item_stall)
        else $error("pending result outside idle");

    // A scroll always starts its sweep from the top of the screen
    a_scroll_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && (state_next == ST_SCROLL_RD) |-> (sweep_reg == '0))
        else $error("scroll sweep not at start");

endmodule
